>>> design/dfe_pkg.sv
package dfe_pkg;

    localparam int DRY_W      = 16;
    localparam int SAMPLE_W   = 18;
    localparam int COEF_W     = 16;
    localparam int DELAY_W    = 17;
    localparam int FB_W       = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int SAT_W      = 24;

    localparam int LINE_DEPTH_DEF = 131072;

    localparam logic [CFG_IDX_W-1:0] REG_ECHO_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PINGPONG_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING_COEFF = 3'd4;

    localparam logic signed [SAT_W-1:0] SAT_HI = 24'sd131071;
    localparam logic signed [SAT_W-1:0] SAT_LO = -24'sd131072;

    // Per-line step strobes from the sequencer
    typedef struct packed {
        logic rd_en;
        logic lp_en;
        logic fb_en;
        logic wr_en;
    } lane_ctl_t;

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SAT_W-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[SAMPLE_W-1:0];
        end
        if (v < SAT_LO) begin
            return SAT_LO[SAMPLE_W-1:0];
        end
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

>>> design/dfe_line.sv
module dfe_line
    import dfe_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  lane_ctl_t                   ctl,
    input  logic [DELAY_W-1:0]          delay,
    input  logic [COEF_W-1:0]           damp,
    input  logic [COEF_W-1:0]           gain,
    input  logic signed [SAMPLE_W-1:0]  wr_data,
    output logic signed [FB_W-1:0]      fb
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam logic [31:0] MAX_DLY = 32'(LINE_DEPTH - 1);
    localparam logic [AW-1:0] LAST_POS = AW'(LINE_DEPTH - 1);
    localparam logic [AW:0] DEPTH_X = (AW + 1)'(LINE_DEPTH);

    logic signed [SAMPLE_W-1:0] mem [LINE_DEPTH];

    logic [AW-1:0]              wp_reg, wp_next;
    logic                       full_reg, full_next;
    logic signed [SAMPLE_W-1:0] smooth_reg, smooth_next;
    logic                       rvalid_reg;
    logic signed [SAMPLE_W-1:0] rdata_reg;
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic signed [35:0]         prod_reg, prod_next;
    logic signed [34:0]         fbprod_reg, fbprod_next;

    logic [31:0]                dly32;
    logic [AW-1:0]              dly;
    logic [AW:0]                wrap_idx;
    logic [AW-1:0]              ridx;
    logic                       rd_hit;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [16:0]         damp_s;
    logic signed [16:0]         gain_s;
    logic signed [35:0]         lp_rnd;
    logic signed [19:0]         lp_corr;
    logic signed [SAT_W-1:0]    lp_sum;
    logic signed [34:0]         fb_rnd;

    // Read position, delay clamped to the line length
    always_comb begin
        dly32 = {{(32 - DELAY_W){1'b0}}, delay};
        if (dly32 > MAX_DLY) begin
            dly32 = MAX_DLY;
        end
        dly      = dly32[AW-1:0];
        wrap_idx = {1'b0, wp_reg} + DEPTH_X - {1'b0, dly};
        ridx     = (wp_reg >= dly) ? (wp_reg - dly) : wrap_idx[AW-1:0];
        // positions not yet written since reset read as zero
        rd_hit   = full_reg || (ridx < wp_reg);
    end

    always_ff @(posedge clk) begin
        if (ctl.wr_en) begin
            mem[wp_reg] <= wr_data;
        end
        if (ctl.rd_en) begin
            rdata_reg <= mem[ridx];
        end
    end

    always_comb begin
        damp_s      = $signed({1'b0, damp});
        gain_s      = $signed({1'b0, gain});
        x_next      = rvalid_reg ? rdata_reg : '0;
        // s' = x + round((s - x) * c)
        diff        = (SAMPLE_W + 1)'(smooth_reg) - (SAMPLE_W + 1)'(x_next);
        prod_next   = 36'(diff) * 36'(damp_s);
        lp_rnd      = prod_reg + 36'sd32768;
        lp_corr     = lp_rnd[35:16];
        lp_sum      = SAT_W'(x_reg) + SAT_W'(lp_corr);
        smooth_next = sat_sample(lp_sum);
        fbprod_next = 35'(smooth_next) * 35'(gain_s);
        fb_rnd      = fbprod_reg + 35'sd32768;
        fb          = fb_rnd[34:16];
        wp_next     = (wp_reg == LAST_POS) ? '0 : wp_reg + 1'b1;
        full_next   = full_reg || (wp_reg == LAST_POS);
    end

    always_ff @(posedge clk) begin
        if (ctl.lp_en) begin
            x_reg    <= x_next;
            prod_reg <= prod_next;
        end
        if (ctl.fb_en) begin
            fbprod_reg <= fbprod_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg     <= '0;
            full_reg   <= 1'b0;
            smooth_reg <= '0;
            rvalid_reg <= 1'b0;
        end
        else begin
            if (ctl.rd_en) begin
                rvalid_reg <= rd_hit;
            end
            if (ctl.fb_en) begin
                smooth_reg <= smooth_next;
            end
            if (ctl.wr_en) begin
                wp_reg   <= wp_next;
                full_reg <= full_next;
            end
        end
    end

endmodule

>>> design/damped_feedback_echo_core.sv
// Mono-in, stereo-out feedback echo. Each line is one single-port-write RAM of LINE_DEPTH
// 18-bit samples with a registered read. An echo sample goes from acceptance to result in
// order: the RAM read issues on the accept edge, then the lowpass multiply, the feedback
// multiply, and write-back with the result loaded into the output register once that
// register is free. In ping-pong mode the two lines work side by side through the same
// steps. With echo disabled a sample passes through the bypass state to the output register.
// The next sample is taken once the block is back in idle, even while the previous result
// still waits in the output register. No clearing pass runs after reset: each line
// keeps a fill mark and reads zero from positions that have not been written since reset.
module damped_feedback_echo_core
    import dfe_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [DRY_W-1:0]     dry_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]  wet_left,
    output logic signed [SAMPLE_W-1:0]  wet_right,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LP   = 3'd1;
    localparam logic [2:0] ST_FB   = 3'd2;
    localparam logic [2:0] ST_WR   = 3'd3;
    localparam logic [2:0] ST_PASS = 3'd4;

    logic [2:0]                 state_reg, state_next;
    logic                       echo_enable_reg;
    logic                       pingpong_mode_reg;
    logic [DELAY_W-1:0]         delay_samples_reg;
    logic [COEF_W-1:0]          feedback_gain_reg;
    logic [COEF_W-1:0]          damping_coeff_reg;
    logic signed [DRY_W-1:0]    dry_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] wet_left_reg, wet_left_next;
    logic signed [SAMPLE_W-1:0] wet_right_reg, wet_right_next;

    logic                       in_take;
    logic                       slot_free;
    logic                       load_out;
    lane_ctl_t                  ctl_l, ctl_r;
    logic signed [FB_W-1:0]     fb_l, fb_r;
    logic signed [SAT_W-1:0]    dry_x;
    logic signed [SAMPLE_W-1:0] line_l_in, line_r_in;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign wet_left  = wet_left_reg;
    assign wet_right = wet_right_reg;

    assign in_take   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb begin
        state_next = state_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    state_next = echo_enable_reg ? ST_LP : ST_PASS;
                end
            end
            ST_LP:   state_next = ST_FB;
            ST_FB:   state_next = ST_WR;
            ST_WR, ST_PASS: begin
                // hold until the output register can take the result
                if (slot_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl_l.rd_en = in_take && echo_enable_reg;
        ctl_l.lp_en = (state_reg == ST_LP);
        ctl_l.fb_en = (state_reg == ST_FB);
        ctl_l.wr_en = (state_reg == ST_WR) && load_out;
        ctl_r.rd_en = ctl_l.rd_en && pingpong_mode_reg;
        ctl_r.lp_en = ctl_l.lp_en && pingpong_mode_reg;
        ctl_r.fb_en = ctl_l.fb_en && pingpong_mode_reg;
        ctl_r.wr_en = ctl_l.wr_en && pingpong_mode_reg;
    end

    always_comb begin
        dry_x = SAT_W'(dry_reg);
        if (pingpong_mode_reg) begin
            line_l_in = sat_sample(dry_x + SAT_W'(fb_r));
            line_r_in = sat_sample(SAT_W'(fb_l));
        end
        else begin
            line_l_in = sat_sample(dry_x + SAT_W'(fb_l));
            line_r_in = line_l_in;
        end
        if (state_reg == ST_PASS) begin
            wet_left_next  = SAMPLE_W'(dry_reg);
            wet_right_next = SAMPLE_W'(dry_reg);
        end
        else begin
            wet_left_next  = line_l_in;
            wet_right_next = line_r_in;
        end
    end

    dfe_line #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_line_l (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_l),
        .delay   (delay_samples_reg),
        .damp    (damping_coeff_reg),
        .gain    (feedback_gain_reg),
        .wr_data (line_l_in),
        .fb      (fb_l)
    );

    dfe_line #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_line_r (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_r),
        .delay   (delay_samples_reg),
        .damp    (damping_coeff_reg),
        .gain    (feedback_gain_reg),
        .wr_data (line_r_in),
        .fb      (fb_r)
    );

    always_ff @(posedge clk) begin
        if (in_take) begin
            dry_reg <= dry_in;
        end
        if (load_out) begin
            wet_left_reg  <= wet_left_next;
            wet_right_reg <= wet_right_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            echo_enable_reg   <= 1'b0;
            pingpong_mode_reg <= 1'b0;
            delay_samples_reg <= '0;
            feedback_gain_reg <= '0;
            damping_coeff_reg <= '0;
        end
        else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ECHO_ENABLE:   echo_enable_reg   <= cfg_data[0];
                    REG_PINGPONG_MODE: pingpong_mode_reg <= cfg_data[0];
                    REG_DELAY_SAMPLES: delay_samples_reg <= cfg_data[DELAY_W-1:0];
                    REG_FEEDBACK_GAIN: feedback_gain_reg <= cfg_data[COEF_W-1:0];
                    REG_DAMPING_COEFF: damping_coeff_reg <= cfg_data[COEF_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    a_bypass_path: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && !echo_enable_reg |=> state_reg == ST_PASS)
        else $error("disabled sample did not take the bypass path");

    a_mono_right_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_r.rd_en || ctl_r.wr_en) |-> pingpong_mode_reg)
        else $error("right line touched in mono mode");

    a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl_l.rd_en && ctl_l.wr_en))
        else $error("line read and write in the same cycle");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_WR || $past(state_reg) == ST_PASS)
        else $error("result loaded outside write-back");

    a_lp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LP |-> $past(ctl_l.rd_en))
        else $error("lowpass step without a preceding line read");

endmodule
